### design/acte_pkg.sv
`timescale 1ns / 1ps

package acte_pkg;

    localparam int MAX_CITIES  = 64;
    localparam int CITY_W      = $clog2(MAX_CITIES);
    localparam int ADDR_W      = 2 * CITY_W;
    localparam int TABLE_DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int CNT_W       = $clog2(MAX_CITIES + 1);
    localparam int LEN_W       = 22;
    localparam int Q_W         = 32;
    localparam int WSUM_W      = Q_W + CITY_W;
    localparam int TH_SPLIT    = (WSUM_W + 1) / 2;

    localparam logic [Q_W-1:0] TRAIL_ONE = 32'd65536;
    localparam logic [Q_W-1:0] SAT_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_START  = 3'd1,
        OP_STEP   = 3'd2,
        OP_FINISH = 3'd3,
        OP_COMMIT = 3'd4,
        OP_REINIT = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ILLEGAL  = 2'd1,
        ST_ZERO_LEN = 2'd2
    } t_status;

    localparam logic [1:0] CFG_ACTIVE  = 2'd0;
    localparam logic [1:0] CFG_RHO     = 2'd1;
    localparam logic [1:0] CFG_DEPOSIT = 2'd2;

endpackage

### design/acte_div.sv
`timescale 1ns / 1ps

module acte_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [acte_pkg::Q_W-1:0]      i_dividend,
    input  logic [acte_pkg::LEN_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [acte_pkg::Q_W-1:0]      o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [$clog2(acte_pkg::Q_W)-1:0] r_cnt;
    logic [acte_pkg::LEN_W-1:0]    r_rem;
    logic [acte_pkg::Q_W-1:0]      r_quo;
    logic [acte_pkg::LEN_W-1:0]    r_div;
    logic [acte_pkg::LEN_W:0]      rem_sh;
    logic [acte_pkg::LEN_W:0]      rem_sub;
    logic                          fits;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_quo[acte_pkg::Q_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign fits    = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sub[acte_pkg::LEN_W-1:0] : rem_sh[acte_pkg::LEN_W-1:0];
                r_quo <= {r_quo[acte_pkg::Q_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### design/ant_colony_tour_engine.sv
`timescale 1ns / 1ps
// ant colony tour engine: builds one ant tour at a time over 64x64 edge tables
// input channel s_*: one operation per transfer, op in s_tuser; output m_*: one
// result per operation (chosen city, tour length, visited count, status).
// configuration channel i_cfg_*: always ready, index 0 active cities, 1 rho,
// 2 deposit quantity; write only while no operation is in flight.
// one operation at a time; s_tready is high only while the sequencer waits.
// what each operation does:
//   load, start, illegal op: straight to the response
//   step: two passes of a read / multiply / accumulate loop
//   finish: tour walks plus the divider
//   commit: read / multiply / write over the whole trail table
//   reinit: one entry per cycle
// the operations share the single 32x32 multiplier and the single table port.
// after reset a clearing pass over all 4096 entries sets every trail to 1.0 and every
// deposit to zero; the input is not ready during it.
// the result sits in an output register; a stalled receiver only holds the
// next operation at its final cycle, nothing is lost.

module ant_colony_tour_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // from_city, to_city, edge_distance, edge_heuristic, rand_frac, zero pad
    input  logic [79:0] s_tdata,
    // op
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chosen_city, tour_length, visited_count, zero pad
    output logic [39:0] m_tdata,
    // status
    output logic [1:0]  m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = acte_pkg::CITY_W;
    localparam int AW = acte_pkg::ADDR_W;
    localparam int NW = acte_pkg::CNT_W;
    localparam int QW = acte_pkg::Q_W;
    localparam int SW = acte_pkg::WSUM_W;
    localparam int HS = acte_pkg::TH_SPLIT;
    localparam int LW = acte_pkg::LEN_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RESP,
        S_ST_CUR0, S_ST_CUR1, S_ST_RD, S_ST_MUL, S_ST_ACC,
        S_TH0, S_TH1, S_TH2, S_APP,
        S_FA, S_FB, S_FC, S_FD, S_FE, S_FDIV, S_FWAIT,
        S_GD, S_GE, S_GF, S_GG,
        S_CA, S_CB, S_CC
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0]  r_active;
    logic [15:0] r_rho;
    logic [15:0] r_qdep;

    // tour state
    logic [acte_pkg::MAX_CITIES-1:0] r_visited;
    logic [NW-1:0] r_count;

    // working registers
    logic          r_init;
    logic [AW-1:0] r_cnt;
    logic [NW-1:0] r_i;
    logic          r_pass;
    logic [CW-1:0] r_cur;
    logic [CW-1:0] r_a;
    logic [CW-1:0] r_b;
    logic [CW-1:0] r_first;
    logic          r_first_ok;
    logic [CW-1:0] r_chosen;
    logic [15:0]   r_frac;
    logic [SW-1:0] r_total;
    logic [SW-1:0] r_run;
    logic [SW-1:0] r_thr;
    logic [HS+15:0] r_thlo;
    logic [LW-1:0] r_sum;
    logic [QW-1:0] r_dep;
    logic [QW-1:0] r_depq;
    logic [2*QW-1:0] r_prod;

    // results
    logic [CW-1:0] r_res_city;
    logic [LW-1:0] r_res_len;
    logic [1:0]    r_res_st;
    logic          r_m_valid;
    logic [39:0]   r_m_data;
    logic [1:0]    r_m_user;

    // memories
    logic [15:0]   mem_dist  [acte_pkg::TABLE_DEPTH];
    logic [QW-1:0] mem_heur  [acte_pkg::TABLE_DEPTH];
    logic [QW-1:0] mem_trail [acte_pkg::TABLE_DEPTH];
    logic [QW-1:0] mem_dep   [acte_pkg::TABLE_DEPTH];
    logic [CW-1:0] mem_tour  [acte_pkg::MAX_CITIES];
    logic [15:0]   r_dist_q;
    logic [QW-1:0] r_heur_q;
    logic [QW-1:0] r_trail_q;
    logic [QW-1:0] r_dep_q;
    logic [CW-1:0] r_tour_q;

    // input fields
    logic [CW-1:0] in_from;
    logic [CW-1:0] in_to;
    logic [15:0]   in_dist;
    logic [QW-1:0] in_heur;
    logic [15:0]   in_frac;
    logic          s_fire;

    assign in_from = s_tdata[5:0];
    assign in_to   = s_tdata[11:6];
    assign in_dist = s_tdata[27:12];
    assign in_heur = s_tdata[59:28];
    assign in_frac = s_tdata[75:60];
    assign s_tready = (r_state == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    logic [NW-1:0] n_lim;
    always_comb begin
        if (r_active < 7'd2) n_lim = NW'(2);
        else if ({1'b0, r_active} > 8'(acte_pkg::MAX_CITIES)) n_lim = NW'(acte_pkg::MAX_CITIES);
        else n_lim = NW'(r_active);
    end

    logic [NW-1:0] i_next;
    logic          i_last;
    assign i_next = r_i + 1'b1;
    assign i_last = (i_next == n_lim);

    // shared multiplier operands
    logic [QW-1:0] mul_a;
    logic [QW-1:0] mul_b;
    always_comb begin
        unique case (r_state)
            S_TH0: begin
                mul_a = QW'(r_total[HS-1:0]);
                mul_b = QW'(r_frac);
            end
            S_TH1: begin
                mul_a = QW'(r_total[SW-1:HS]);
                mul_b = QW'(r_frac);
            end
            S_CB: begin
                mul_a = r_trail_q;
                mul_b = QW'(r_rho);
            end
            default: begin
                mul_a = r_trail_q;
                mul_b = r_heur_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    logic [QW-1:0] weight;
    logic [SW-1:0] tot_nx;
    logic [SW-1:0] run_nx;
    logic [HS+16+HS-1:0] thr_full;
    assign weight   = r_prod[2*QW-1:QW];
    assign tot_nx   = r_total + SW'(weight);
    assign run_nx   = r_run + SW'(weight);
    assign thr_full = {r_prod[HS+15:0], {HS{1'b0}}} + (2*HS+16)'(r_thlo);

    logic [QW:0] dep_add;
    logic [QW:0] com_add;
    assign dep_add = {1'b0, r_dep_q} + {1'b0, r_dep};
    assign com_add = {1'b0, r_prod[QW+15:16]} + {1'b0, r_depq};

    // table addressing
    logic [AW-1:0] tab_ra;
    logic [AW-1:0] tab_wa;
    logic          trail_we;
    logic [QW-1:0] trail_wd;
    logic          dep_we;
    logic [QW-1:0] dep_wd;
    logic [CW-1:0] tour_ra;
    logic          tour_we;
    logic [CW-1:0] tour_wa;
    logic [CW-1:0] tour_wd;
    logic          load_we;

    always_comb begin
        tab_ra   = r_cnt;
        tab_wa   = r_cnt;
        trail_we = 1'b0;
        trail_wd = acte_pkg::TRAIL_ONE;
        dep_we   = 1'b0;
        dep_wd   = '0;
        tour_ra  = r_i[CW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                trail_we = 1'b1;
                dep_we   = 1'b1;
            end
            S_ST_RD: tab_ra = {r_cur, r_i[CW-1:0]};
            S_ST_CUR0: tour_ra = CW'(r_count - 1'b1);
            S_FB: tour_ra = i_last ? '0 : i_next[CW-1:0];
            S_FD, S_GD: tab_ra = {r_a, r_b};
            S_GF: tab_ra = {r_b, r_a};
            S_GE: begin
                tab_wa = {r_a, r_b};
                dep_we = 1'b1;
                dep_wd = dep_add[QW] ? acte_pkg::SAT_MAX : dep_add[QW-1:0];
            end
            S_GG: begin
                tab_wa = {r_b, r_a};
                dep_we = 1'b1;
                dep_wd = dep_add[QW] ? acte_pkg::SAT_MAX : dep_add[QW-1:0];
            end
            S_CC: begin
                trail_we = 1'b1;
                trail_wd = com_add[QW] ? acte_pkg::SAT_MAX : com_add[QW-1:0];
                dep_we   = 1'b1;
            end
            default: ;
        endcase
    end

    assign load_we = s_fire && (s_tuser == acte_pkg::OP_LOAD);
    assign tour_we = (s_fire && (s_tuser == acte_pkg::OP_START) && (NW'(in_from) < n_lim))
                     || (r_state == S_APP);
    assign tour_wa = (r_state == S_APP) ? r_count[CW-1:0] : '0;
    assign tour_wd = (r_state == S_APP) ? r_chosen : in_from;

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_dist[{in_from, in_to}] <= in_dist;
            mem_heur[{in_from, in_to}] <= in_heur;
        end
        r_dist_q <= mem_dist[tab_ra];
        r_heur_q <= mem_heur[tab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (trail_we) mem_trail[tab_wa] <= trail_wd;
        r_trail_q <= mem_trail[tab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) mem_dep[tab_wa] <= dep_wd;
        r_dep_q <= mem_dep[tab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tour_we) mem_tour[tour_wa] <= tour_wd;
        r_tour_q <= mem_tour[tour_ra];
    end

    // divider for the deposit amount
    logic          div_start;
    logic          div_done;
    logic [QW-1:0] div_quo;
    assign div_start = (r_state == S_FDIV) && (r_sum != '0);

    acte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_qdep, 16'd0}),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 7'd51;
            r_rho     <= 16'd32768;
            r_qdep    <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                acte_pkg::CFG_ACTIVE:  r_active <= i_cfg_data[6:0];
                acte_pkg::CFG_RHO:     r_rho    <= i_cfg_data;
                acte_pkg::CFG_DEPOSIT: r_qdep   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_init    <= 1'b1;
            r_cnt     <= '0;
            r_visited <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (m_tready && r_state != S_RESP) r_m_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) begin
                        r_state <= r_init ? S_IDLE : S_RESP;
                        r_init  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        r_res_city <= '0;
                        r_res_len  <= '0;
                        r_res_st   <= acte_pkg::ST_OK;
                        r_frac     <= in_frac;
                        r_cnt      <= '0;
                        r_i        <= '0;
                        r_state    <= S_RESP;
                        unique case (s_tuser)
                            acte_pkg::OP_LOAD: ;
                            acte_pkg::OP_START: begin
                                if (NW'(in_from) < n_lim) begin
                                    r_visited  <= {{(acte_pkg::MAX_CITIES-1){1'b0}}, 1'b1}
                                                  << in_from;
                                    r_count    <= NW'(1);
                                    r_res_city <= in_from;
                                end else begin
                                    r_res_st <= acte_pkg::ST_ILLEGAL;
                                end
                            end
                            acte_pkg::OP_STEP: begin
                                if (r_count != '0 && r_count < n_lim) r_state <= S_ST_CUR0;
                                else r_res_st <= acte_pkg::ST_ILLEGAL;
                            end
                            acte_pkg::OP_FINISH: begin
                                if (r_count == n_lim) begin
                                    r_state <= S_FA;
                                    r_pass  <= 1'b0;
                                    r_sum   <= '0;
                                end else begin
                                    r_res_st <= acte_pkg::ST_ILLEGAL;
                                end
                            end
                            acte_pkg::OP_COMMIT: r_state <= S_CA;
                            acte_pkg::OP_REINIT: r_state <= S_CLEAR;
                            default: r_res_st <= acte_pkg::ST_ILLEGAL;
                        endcase
                    end
                end
                S_RESP: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {5'd0, r_count, r_res_len, r_res_city};
                        r_m_user  <= r_res_st;
                        r_state   <= S_IDLE;
                    end
                end
                S_ST_CUR0: r_state <= S_ST_CUR1;
                S_ST_CUR1: begin
                    r_cur      <= r_tour_q;
                    r_i        <= '0;
                    r_pass     <= 1'b0;
                    r_total    <= '0;
                    r_first_ok <= 1'b0;
                    r_state    <= S_ST_RD;
                end
                S_ST_RD: begin
                    if (r_i == n_lim) begin
                        if (!r_pass) begin
                            r_state <= S_TH0;
                        end else begin
                            r_chosen <= r_first;
                            r_state  <= S_APP;
                        end
                    end else if (r_visited[r_i[CW-1:0]]) begin
                        r_i <= i_next;
                    end else begin
                        r_state <= S_ST_MUL;
                    end
                end
                S_ST_MUL: r_state <= S_ST_ACC;
                S_ST_ACC: begin
                    r_state <= S_ST_RD;
                    r_i     <= i_next;
                    if (!r_pass) begin
                        r_total <= tot_nx;
                        if (!r_first_ok) begin
                            r_first_ok <= 1'b1;
                            r_first    <= r_i[CW-1:0];
                        end
                    end else begin
                        r_run <= run_nx;
                        if (run_nx >= r_thr) begin
                            r_chosen <= r_i[CW-1:0];
                            r_state  <= S_APP;
                        end
                    end
                end
                S_TH0: r_state <= S_TH1;
                S_TH1: begin
                    r_thlo  <= r_prod[HS+15:0];
                    r_state <= S_TH2;
                end
                S_TH2: begin
                    // threshold is (frac * total) >> 16 from two partial products
                    r_thr   <= thr_full[SW+15:16];
                    r_run   <= '0;
                    r_i     <= '0;
                    r_pass  <= 1'b1;
                    r_state <= S_ST_RD;
                end
                S_APP: begin
                    r_visited[r_chosen] <= 1'b1;
                    r_count    <= r_count + 1'b1;
                    r_res_city <= r_chosen;
                    r_state    <= S_RESP;
                end
                S_FA: r_state <= S_FB;
                S_FB: begin
                    r_a     <= r_tour_q;
                    r_state <= S_FC;
                end
                S_FC: begin
                    r_b     <= r_tour_q;
                    r_state <= r_pass ? S_GD : S_FD;
                end
                S_FD: r_state <= S_FE;
                S_FE: begin
                    r_sum <= r_sum + LW'(r_dist_q);
                    r_i   <= i_next;
                    if (i_last) r_state <= S_FDIV;
                    else r_state <= S_FA;
                end
                S_FDIV: begin
                    if (r_sum == '0) begin
                        r_res_st <= acte_pkg::ST_ZERO_LEN;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    if (div_done) begin
                        r_dep   <= div_quo;
                        r_i     <= '0;
                        r_pass  <= 1'b1;
                        r_state <= S_FA;
                    end
                end
                S_GD: r_state <= S_GE;
                S_GE: r_state <= S_GF;
                S_GF: r_state <= S_GG;
                S_GG: begin
                    r_i <= i_next;
                    if (i_last) begin
                        r_res_len <= r_sum;
                        r_state   <= S_RESP;
                    end else begin
                        r_state <= S_FA;
                    end
                end
                S_CA: r_state <= S_CB;
                S_CB: begin
                    r_depq  <= r_dep_q;
                    r_state <= S_CC;
                end
                S_CC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) r_state <= S_RESP;
                    else r_state <= S_CA;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_user;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(acte_pkg::MAX_CITIES))
        else $error("tour count above city limit");

    a_append_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APP) |-> !r_visited[r_chosen])
        else $error("step appended a visited city");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == acte_pkg::ST_OK) || (m_tuser == acte_pkg::ST_ILLEGAL)
                     || (m_tuser == acte_pkg::ST_ZERO_LEN))
        else $error("undefined status code");

    a_step_has_tour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST_RD) |-> (r_count != '0) && (r_count < n_lim))
        else $error("roulette running without a partial tour");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int PHASE_ITEMS    = 300;

    typedef struct packed {
        logic [5:0]        city;
        logic [21:0]       length;
        logic [6:0]        count;
        acte_pkg::t_status status;
    } t_outcome;

    typedef enum logic [1:0] { ROW_OP, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind    kind;
        acte_pkg::t_op op;
        logic [5:0]   from_c;
        logic [5:0]   to_c;
        logic [15:0]  distance;
        logic [31:0]  heur;
        logic [15:0]  frac;
        logic [1:0]   cfg_idx;
        logic [15:0]  cfg_val;
        bit           typed;
        t_outcome     outcome;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    ant_colony_tour_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // engine mirror
    logic [15:0] dist_mem  [acte_pkg::TABLE_DEPTH];
    logic [31:0] heur_mem  [acte_pkg::TABLE_DEPTH];
    logic [31:0] trail_mem [acte_pkg::TABLE_DEPTH];
    logic [31:0] dep_mem   [acte_pkg::TABLE_DEPTH];
    bit          edge_known[acte_pkg::TABLE_DEPTH];
    bit          visited   [acte_pkg::MAX_CITIES];
    logic [5:0]  route     [acte_pkg::MAX_CITIES];
    int unsigned route_len;
    logic [6:0]  cfg_active;
    logic [15:0] cfg_rho;
    logic [15:0] cfg_quantity;

    t_outcome    pending_results[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          items_sent;
    int          results_seen;
    int          tours_closed;
    int          commits_done;
    int          idle_cycles;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int unsigned city_span();
        if (cfg_active < 2) return 2;
        if (cfg_active > acte_pkg::MAX_CITIES) return acte_pkg::MAX_CITIES;
        return cfg_active;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? acte_pkg::SAT_MAX : s[31:0];
    endfunction

    // advances the mirror by one operation and returns its result
    function automatic t_outcome run_engine(acte_pkg::t_op op, logic [5:0] from_c,
                                            logic [5:0] to_c, logic [15:0] distance,
                                            logic [31:0] heur, logic [15:0] frac);
        t_outcome    r;
        int unsigned lim;
        int unsigned cur;
        int unsigned a;
        int unsigned b;
        logic [63:0] total;
        logic [63:0] acc;
        logic [63:0] prod;
        logic [63:0] thr;
        logic [31:0] sum;
        logic [31:0] dep;
        logic [47:0] evap;
        bit          found;
        r = '{city: '0, length: '0, count: '0, status: acte_pkg::ST_OK};
        lim = city_span();
        case (op)
            acte_pkg::OP_LOAD: begin
                dist_mem[{from_c, to_c}] = distance;
                heur_mem[{from_c, to_c}] = heur;
                edge_known[{from_c, to_c}] = 1'b1;
            end
            acte_pkg::OP_START: begin
                if (from_c < lim) begin
                    foreach (visited[i]) visited[i] = 1'b0;
                    route[0] = from_c;
                    route_len = 1;
                    visited[from_c] = 1'b1;
                    r.city = from_c;
                end else begin
                    r.status = acte_pkg::ST_ILLEGAL;
                end
            end
            acte_pkg::OP_STEP: begin
                if (route_len >= 1 && route_len < lim) begin
                    cur = route[route_len - 1];
                    total = '0;
                    acc = '0;
                    found = 1'b0;
                    for (int i = 0; i < lim; i++) begin
                        if (!visited[i]) begin
                            prod = {32'd0, trail_mem[cur * 64 + i]} * heur_mem[cur * 64 + i];
                            total += prod >> 32;
                        end
                    end
                    thr = ({48'd0, frac} * total) >> 16;
                    for (int i = 0; i < lim && !found; i++) begin
                        if (!visited[i]) begin
                            prod = {32'd0, trail_mem[cur * 64 + i]} * heur_mem[cur * 64 + i];
                            acc += prod >> 32;
                            if (acc >= thr) begin
                                r.city = i;
                                found = 1'b1;
                            end
                        end
                    end
                    // nothing reached the threshold: first free city
                    for (int i = 0; i < lim && !found; i++) begin
                        if (!visited[i]) begin
                            r.city = i;
                            found = 1'b1;
                        end
                    end
                    route[route_len] = r.city;
                    route_len++;
                    visited[r.city] = 1'b1;
                end else begin
                    r.status = acte_pkg::ST_ILLEGAL;
                end
            end
            acte_pkg::OP_FINISH: begin
                if (route_len == lim) begin
                    sum = '0;
                    for (int i = 0; i < lim; i++) begin
                        sum += dist_mem[route[i] * 64 + route[(i + 1) % lim]];
                    end
                    if (sum == 0) begin
                        r.status = acte_pkg::ST_ZERO_LEN;
                    end else begin
                        dep = {cfg_quantity, 16'd0} / sum;
                        r.length = sum[21:0];
                        for (int i = 0; i < lim; i++) begin
                            a = route[i];
                            b = route[(i + 1) % lim];
                            dep_mem[a * 64 + b] = sat_add(dep_mem[a * 64 + b], dep);
                            dep_mem[b * 64 + a] = sat_add(dep_mem[b * 64 + a], dep);
                        end
                    end
                end else begin
                    r.status = acte_pkg::ST_ILLEGAL;
                end
            end
            acte_pkg::OP_COMMIT: begin
                for (int i = 0; i < acte_pkg::TABLE_DEPTH; i++) begin
                    evap = ({32'd0, cfg_rho} * trail_mem[i]) >> 16;
                    trail_mem[i] = sat_add(evap[31:0], dep_mem[i]);
                    dep_mem[i] = '0;
                end
            end
            acte_pkg::OP_REINIT: begin
                for (int i = 0; i < acte_pkg::TABLE_DEPTH; i++) begin
                    trail_mem[i] = acte_pkg::TRAIL_ONE;
                    dep_mem[i] = '0;
                end
            end
            default: r.status = acte_pkg::ST_ILLEGAL;
        endcase
        r.count = route_len[6:0];
        return r;
    endfunction

    task automatic send_op(acte_pkg::t_op op, logic [5:0] from_c, logic [5:0] to_c,
                           logic [15:0] distance, logic [31:0] heur, logic [15:0] frac,
                           bit typed, t_outcome fixed);
        t_outcome r;
        r = run_engine(op, from_c, to_c, distance, heur, frac);
        pending_results.push_back(typed ? fixed : r);
        if (op == acte_pkg::OP_FINISH && r.status == acte_pkg::ST_OK) tours_closed++;
        if (op == acte_pkg::OP_COMMIT) commits_done++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, frac, heur, distance, to_c, from_c};
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic load_edge(int unsigned a, int unsigned b);
        logic [15:0] d;
        d = ($urandom_range(7) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
        send_op(acte_pkg::OP_LOAD, a[5:0], b[5:0], d, $urandom, $urandom, 1'b0, '0);
    endtask

    // makes sure the edges an operation will read have been written
    task automatic prepare_edges(acte_pkg::t_op op);
        int unsigned lim;
        int unsigned cur;
        int unsigned a;
        int unsigned b;
        lim = city_span();
        if (op == acte_pkg::OP_STEP && route_len >= 1 && route_len < lim) begin
            cur = route[route_len - 1];
            for (int i = 0; i < lim; i++) begin
                if (!visited[i] && !edge_known[cur * 64 + i]) load_edge(cur, i);
            end
        end else if (op == acte_pkg::OP_FINISH && route_len == lim) begin
            for (int i = 0; i < lim; i++) begin
                a = route[i];
                b = route[(i + 1) % lim];
                if (!edge_known[a * 64 + b]) load_edge(a, b);
            end
        end
    endtask

    task automatic issue(acte_pkg::t_op op, logic [5:0] from_c);
        prepare_edges(op);
        send_op(op, from_c, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            acte_pkg::CFG_ACTIVE:  cfg_active = val[6:0];
            acte_pkg::CFG_RHO:     cfg_rho = val;
            acte_pkg::CFG_DEPOSIT: cfg_quantity = val;
            default: ;
        endcase
    endtask

    function automatic t_row op_row(acte_pkg::t_op op, logic [5:0] f, logic [5:0] t,
                                    logic [15:0] d, logic [31:0] h, logic [15:0] q);
        t_row row;
        row = '{kind: ROW_OP, op: op, from_c: f, to_c: t, distance: d, heur: h, frac: q,
                cfg_idx: '0, cfg_val: '0, typed: 1'b0, outcome: '0};
        return row;
    endfunction

    function automatic t_row typed_row(acte_pkg::t_op op, logic [5:0] f, logic [5:0] c,
                                       logic [6:0] n, acte_pkg::t_status st);
        t_row row;
        row = op_row(op, f, '0, '0, '0, '0);
        row.typed = 1'b1;
        row.outcome = '{city: c, length: '0, count: n, status: st};
        return row;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [15:0] val);
        t_row row;
        row = op_row(acte_pkg::OP_LOAD, '0, '0, '0, '0, '0);
        row.kind = ROW_CFG;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    task automatic run_directed();
        t_row rows[$];
        rows.push_back(typed_row(acte_pkg::OP_STEP, 6'd0, 6'd0, 7'd0, acte_pkg::ST_ILLEGAL));
        rows.push_back(typed_row(acte_pkg::t_op'(3'd6), 6'd0, 6'd0, 7'd0,
                                 acte_pkg::ST_ILLEGAL));
        rows.push_back(typed_row(acte_pkg::t_op'(3'd7), 6'd0, 6'd0, 7'd0,
                                 acte_pkg::ST_ILLEGAL));
        rows.push_back(typed_row(acte_pkg::OP_START, 6'd63, 6'd0, 7'd0, acte_pkg::ST_ILLEGAL));
        rows.push_back(typed_row(acte_pkg::OP_FINISH, 6'd0, 6'd0, 7'd0, acte_pkg::ST_ILLEGAL));
        rows.push_back(op_row(acte_pkg::OP_COMMIT, 6'd63, 6'd63, 16'hFFFF, 32'hFFFF_FFFF,
                              16'hFFFF));
        rows.push_back(op_row(acte_pkg::OP_REINIT, '0, '0, '0, '0, '0));
        // active count below two behaves as two
        rows.push_back(cfg_row(acte_pkg::CFG_ACTIVE, 16'd0));
        rows.push_back(cfg_row(acte_pkg::CFG_DEPOSIT, 16'hFFFF));
        rows.push_back(cfg_row(acte_pkg::CFG_RHO, 16'hFFFF));
        rows.push_back(op_row(acte_pkg::OP_LOAD, 6'd0, 6'd1, 16'd1, 32'hFFFF_FFFF, 16'd0));
        rows.push_back(op_row(acte_pkg::OP_LOAD, 6'd1, 6'd0, 16'd0, 32'd0, 16'd0));
        rows.push_back(typed_row(acte_pkg::OP_START, 6'd0, 6'd0, 7'd1, acte_pkg::ST_OK));
        rows.push_back(op_row(acte_pkg::OP_STEP, '0, '0, '0, '0, 16'hFFFF));
        rows.push_back(typed_row(acte_pkg::OP_STEP, 6'd0, 6'd0, 7'd2, acte_pkg::ST_ILLEGAL));
        rows.push_back(op_row(acte_pkg::OP_FINISH, '0, '0, '0, '0, '0));
        // both finishes on the same tour saturate the deposits
        rows.push_back(op_row(acte_pkg::OP_FINISH, '0, '0, '0, '0, '0));
        rows.push_back(op_row(acte_pkg::OP_COMMIT, '0, '0, '0, '0, '0));
        rows.push_back(typed_row(acte_pkg::OP_START, 6'd2, 6'd0, 7'd2, acte_pkg::ST_ILLEGAL));
        rows.push_back(op_row(acte_pkg::OP_LOAD, 6'd0, 6'd1, 16'd0, 32'h8000_0000, 16'd0));
        rows.push_back(typed_row(acte_pkg::OP_FINISH, 6'd0, 6'd0, 7'd2,
                                 acte_pkg::ST_ZERO_LEN));
        // active count above the table size behaves as the table size
        rows.push_back(cfg_row(acte_pkg::CFG_ACTIVE, 16'd127));
        rows.push_back(typed_row(acte_pkg::OP_START, 6'd63, 6'd63, 7'd1, acte_pkg::ST_OK));
        rows.push_back(cfg_row(acte_pkg::CFG_RHO, 16'd0));
        rows.push_back(op_row(acte_pkg::OP_COMMIT, '0, '0, '0, '0, '0));
        rows.push_back(op_row(acte_pkg::OP_REINIT, '0, '0, '0, '0, '0));
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                write_reg(rows[k].cfg_idx, rows[k].cfg_val);
            end else begin
                send_op(rows[k].op, rows[k].from_c, rows[k].to_c, rows[k].distance,
                        rows[k].heur, rows[k].frac, rows[k].typed, rows[k].outcome);
            end
        end
    endtask

    task automatic new_setting();
        int unsigned pick;
        pick = $urandom_range(99);
        case ($urandom_range(2))
            0: begin
                if (pick < 85) write_reg(acte_pkg::CFG_ACTIVE, 16'($urandom_range(2, 12)));
                else if (pick < 95) write_reg(acte_pkg::CFG_ACTIVE,
                                              16'($urandom_range(13, 20)));
                else write_reg(acte_pkg::CFG_ACTIVE, 16'd64);
            end
            1: write_reg(acte_pkg::CFG_RHO,
                         pick < 15 ? 16'd0 : (pick < 30 ? 16'hFFFF : 16'($urandom)));
            default: write_reg(acte_pkg::CFG_DEPOSIT,
                               pick < 15 ? 16'd0 : (pick < 30 ? 16'hFFFF : 16'($urandom)));
        endcase
    endtask

    task automatic run_random_phase();
        int unsigned   start_count;
        int unsigned   lim;
        int unsigned   steps;
        acte_pkg::t_op op;
        start_count = items_sent;
        write_reg(acte_pkg::CFG_ACTIVE, 16'($urandom_range(2, 10)));
        while (items_sent - start_count < PHASE_ITEMS) begin
            if ($urandom_range(5) == 0) new_setting();
            lim = city_span();
            if ($urandom_range(99) < 80) begin
                issue(acte_pkg::OP_START, 6'($urandom_range(lim - 1)));
                steps = (lim <= 20) ? lim - 1 : $urandom_range(1, 4);
                if ($urandom_range(9) == 0) steps = $urandom_range(steps);
                repeat (steps) issue(acte_pkg::OP_STEP, '0);
                issue(acte_pkg::OP_FINISH, '0);
                if ($urandom_range(7) == 0) issue(acte_pkg::OP_FINISH, '0);
                if ($urandom_range(9) == 0) issue(acte_pkg::OP_COMMIT, '0);
                if ($urandom_range(24) == 0) issue(acte_pkg::OP_REINIT, '0);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    op = acte_pkg::t_op'($urandom_range(7));
                    if ((op == acte_pkg::OP_COMMIT || op == acte_pkg::OP_REINIT)
                        && $urandom_range(3) != 0)
                        op = acte_pkg::OP_STEP;
                    issue(op, $urandom);
                end
            end
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            got = '{city: m_tdata[5:0], length: m_tdata[27:6], count: m_tdata[34:28],
                    status: acte_pkg::t_status'(m_tuser)};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[39:35] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p, got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        tours_closed = 0;
        commits_done = 0;
        route_len = 0;
        cfg_active = 7'd51;
        cfg_rho = 16'd32768;
        cfg_quantity = 16'd100;
        for (int i = 0; i < acte_pkg::TABLE_DEPTH; i++) begin
            dist_mem[i] = '0;
            heur_mem[i] = '0;
            trail_mem[i] = acte_pkg::TRAIL_ONE;
            dep_mem[i] = '0;
            edge_known[i] = 1'b0;
        end
        foreach (visited[i]) visited[i] = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 60;
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random_phase();
        send_idle_pct = 60;
        recv_idle_pct = 38;
        run_random_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase();
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d operations and %0d results: %0d closed tours, %0d commits,",
                 items_sent, results_seen, tours_closed, commits_done);
        $display("active counts from the minimum to the full table, stalls on both sides");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
design/acte_pkg.sv
design/acte_div.sv
design/ant_colony_tour_engine.sv
test/tb_top.sv
